@@ sv/p2rb_pkg.sv @@
// ----------------------------------------------------------------------------
// p2rb_pkg
// Shared types, format codes and a packing helper for the RGB565 blend core.
// ----------------------------------------------------------------------------
package p2rb_pkg;

	typedef enum logic [2:0] {
		FMT_RGB565         = 3'd0,
		FMT_RGB565_SWAPPED = 3'd1,
		FMT_RGB888         = 3'd2,
		FMT_ARGB8888       = 3'd3
	} fmt_t;

	localparam logic [7:0] MASK_R5     = 8'hF8;
	localparam logic [7:0] MASK_G6     = 8'hFC;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [7:0] rm;
		logic [7:0] gm;
		rm = r & MASK_R5;
		gm = g & MASK_G6;
		return {rm[7:3], gm[7:2], b[7:3]};
	endfunction

endpackage

@@ sv/p2rb_in_if.sv @@
// ----------------------------------------------------------------------------
// p2rb_in_if
// Source pixel channel: valid/ready handshake with pixel bytes and format.
// ----------------------------------------------------------------------------
interface p2rb_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_bytes;
	logic [2:0]  source_format;

	modport source (output valid, output pixel_bytes, output source_format, input ready);
	modport sink   (input valid, input pixel_bytes, input source_format, output ready);
endinterface

@@ sv/p2rb_out_if.sv @@
// ----------------------------------------------------------------------------
// p2rb_out_if
// Converted pixel channel: valid/ready handshake with one RGB565 word.
// ----------------------------------------------------------------------------
interface p2rb_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] rgb565_pixel;

	modport source (output valid, output rgb565_pixel, input ready);
	modport sink   (input valid, input rgb565_pixel, output ready);
endinterface

@@ sv/p2rb_blend_lane.sv @@
// ----------------------------------------------------------------------------
// p2rb_blend_lane
// One color channel blend: products in stage 1, sum in stage 2, and an
// exact divide by 255 on the registered sum.
// ----------------------------------------------------------------------------
module p2rb_blend_lane (
	input  logic                 clk,
	input  p2rb_pkg::stage_en_t  en,
	input  logic [7:0]           fg,
	input  logic [7:0]           bg,
	input  logic [7:0]           alpha,
	output logic [7:0]           quo
);

	logic [15:0] prod_fg_s1;
	logic [15:0] prod_bg_s1;
	logic [15:0] sum_s2;
	logic [7:0]  inv_alpha;
	logic [16:0] div_tmp;

	assign inv_alpha = p2rb_pkg::ALPHA_OPAQUE - alpha;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_fg_s1 <= {8'd0, fg} * {8'd0, alpha};
			prod_bg_s1 <= {8'd0, bg} * {8'd0, inv_alpha};
		end
		if (en.s2) begin
			sum_s2 <= prod_fg_s1 + prod_bg_s1;
		end
	end

	// x / 255 == (x + (x >> 8) + 1) >> 8 for x up to 255 * 255
	assign div_tmp = {1'b0, sum_s2} + {9'd0, sum_s2[15:8]} + 17'd1;
	assign quo     = div_tmp[15:8];

endmodule

@@ sv/pixel_to_rgb565_blend_core.sv @@
// ----------------------------------------------------------------------------
// pixel_to_rgb565_blend_core
// Converts RGB565, swapped RGB565, RGB888 and ARGB8888 pixels to RGB565,
// blending translucent ARGB pixels over the background color; unknown format
// codes yield the background color. Pipeline: three register stages s1 to s3.
// Throughput: one item per cycle unless the output stalls; each stage holds independently on a stall.
// Reset: arst_n clears stage valid bits and the background color bg_q to 0.
// ----------------------------------------------------------------------------
module pixel_to_rgb565_blend_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	p2rb_in_if.sink     in_px,
	p2rb_out_if.source  out_px
);

	logic [15:0] bg_q;
	logic        v1_s1, v2_s2, v3_s3;
	logic        en1, en2, en3;
	logic        blend_s1, blend_s2;
	logic [15:0] direct_s1, direct_s2;
	logic [15:0] pixel_s3;
	logic        blend_in;
	logic [15:0] direct_in;
	logic [7:0]  b0, b1, b2, b3;
	logic [7:0]  q_r, q_g, q_b;
	p2rb_pkg::stage_en_t lane_en;

	assign en3 = !v3_s3 || out_px.ready;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign in_px.ready = en1;
	assign lane_en.s1 = en1;
	assign lane_en.s2 = en2;

	assign b0 = in_px.pixel_bytes[7:0];
	assign b1 = in_px.pixel_bytes[15:8];
	assign b2 = in_px.pixel_bytes[23:16];
	assign b3 = in_px.pixel_bytes[31:24];

	always_comb begin
		blend_in = 1'b0;
		case (p2rb_pkg::fmt_t'(in_px.source_format))
			p2rb_pkg::FMT_RGB565:         direct_in = {b1, b0};
			p2rb_pkg::FMT_RGB565_SWAPPED: direct_in = {b0, b1};
			p2rb_pkg::FMT_RGB888:         direct_in = p2rb_pkg::pack565(b2, b1, b0);
			p2rb_pkg::FMT_ARGB8888: begin
				direct_in = p2rb_pkg::pack565(b2, b1, b0);
				blend_in  = (b3 != p2rb_pkg::ALPHA_OPAQUE);
			end
			default:                      direct_in = bg_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= 16'd0;
		end else if (cfg_wr_en) begin
			bg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= in_px.valid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			blend_s1  <= blend_in;
			direct_s1 <= direct_in;
		end
		if (en2) begin
			blend_s2  <= blend_s1;
			direct_s2 <= direct_s1;
		end
		if (en3) begin
			pixel_s3 <= blend_s2 ? p2rb_pkg::pack565(q_r, q_g, q_b) : direct_s2;
		end
	end

	// background channels widened to 8 bits
	p2rb_blend_lane u_lane_r (
		.clk(clk), .en(lane_en), .fg(b2), .bg({bg_q[15:11], 3'b000}), .alpha(b3), .quo(q_r)
	);
	p2rb_blend_lane u_lane_g (
		.clk(clk), .en(lane_en), .fg(b1), .bg({bg_q[10:5], 2'b00}), .alpha(b3), .quo(q_g)
	);
	p2rb_blend_lane u_lane_b (
		.clk(clk), .en(lane_en), .fg(b0), .bg({bg_q[4:0], 3'b000}), .alpha(b3), .quo(q_b)
	);

	assign out_px.valid        = v3_s3;
	assign out_px.rgb565_pixel = pixel_s3;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && v2_s2 && v3_s3 && !out_px.ready) |-> !in_px.ready)
		else $error("full stalled pipeline still takes an item");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_px.valid && in_px.ready) |=> v1_s1)
		else $error("accepted item missing from stage 1");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && out_px.ready && !v2_s2) |=> !v3_s3)
		else $error("delivered item repeated at output");

endmodule

@@ tb/sv/pixel_to_rgb565_blend_core_tb.sv @@
// ----------------------------------------------------------------------------
// pixel_to_rgb565_blend_core_tb
// Self-checking bench for the RGB565 converter. A short table of directed
// pixels comes first: format extremes, unused bytes, opaque, zero and partial
// alpha, and unknown format codes under several background colors. Random
// pixels follow in three handshake phases with changing background colors.
// Every result is checked in order against a table value or a local conversion model.
// ----------------------------------------------------------------------------
module pixel_to_rgb565_blend_core_tb;

	localparam logic [2:0] FMT_UNSUP_4 = 3'd4;
	localparam logic [2:0] FMT_UNSUP_5 = 3'd5;
	localparam logic [2:0] FMT_UNSUP_6 = 3'd6;
	localparam logic [2:0] FMT_UNSUP_7 = 3'd7;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int TAIL_CYCLES    = 8;
	localparam int BLOCK_ITEMS    = 120;
	localparam int BLOCKS_PER_RUN = 4;
	localparam int N_DIRECTED     = 25;

	typedef struct {
		logic [15:0] bg;
		logic [31:0] bytes;
		logic [2:0]  fmt;
		bit          typed;
		logic [15:0] want;
	} pixel_row_t;

	pixel_row_t dir_rows [0:N_DIRECTED-1] = '{
		'{16'h0000, 32'h0000_0000, p2rb_pkg::FMT_RGB565,         1'b1, 16'h0000},
		'{16'h0000, 32'hFFFF_FFFF, p2rb_pkg::FMT_RGB565,         1'b1, 16'hFFFF},
		'{16'h0000, 32'hABCD_1234, p2rb_pkg::FMT_RGB565,         1'b1, 16'h1234},
		'{16'h0000, 32'h5A5A_1234, p2rb_pkg::FMT_RGB565_SWAPPED, 1'b1, 16'h3412},
		'{16'h0000, 32'hFFFF_FFFF, p2rb_pkg::FMT_RGB888,         1'b1, 16'hFFFF},
		'{16'h0000, 32'hFF00_0000, p2rb_pkg::FMT_RGB888,         1'b1, 16'h0000},
		'{16'h0000, 32'h0000_0000, p2rb_pkg::FMT_ARGB8888,       1'b1, 16'h0000},
		'{16'h0000, 32'hFFFF_FFFF, p2rb_pkg::FMT_ARGB8888,       1'b1, 16'hFFFF},
		'{16'h0000, 32'hFF12_3456, p2rb_pkg::FMT_ARGB8888,       1'b0, 16'h0000},
		'{16'h0000, 32'h1234_5678, FMT_UNSUP_4,                  1'b1, 16'h0000},
		'{16'h0000, 32'hFFFF_FFFF, FMT_UNSUP_7,                  1'b1, 16'h0000},
		'{16'h0000, 32'h80FF_FFFF, p2rb_pkg::FMT_ARGB8888,       1'b0, 16'h0000},
		'{16'hFFFF, 32'h0000_0000, FMT_UNSUP_5,                  1'b1, 16'hFFFF},
		'{16'hFFFF, 32'h0000_0000, p2rb_pkg::FMT_ARGB8888,       1'b1, 16'hFFFF},
		'{16'hFFFF, 32'h0012_3456, p2rb_pkg::FMT_ARGB8888,       1'b1, 16'hFFFF},
		'{16'hFFFF, 32'h7F00_0000, p2rb_pkg::FMT_ARGB8888,       1'b0, 16'h0000},
		'{16'hFFFF, 32'hFE00_0000, p2rb_pkg::FMT_ARGB8888,       1'b0, 16'h0000},
		'{16'hFFFF, 32'h0100_0000, p2rb_pkg::FMT_ARGB8888,       1'b0, 16'h0000},
		'{16'hF81F, 32'h0000_0000, FMT_UNSUP_6,                  1'b1, 16'hF81F},
		'{16'hF81F, 32'h00AB_CDEF, p2rb_pkg::FMT_ARGB8888,       1'b1, 16'hF81F},
		'{16'hF81F, 32'h40FF_FFFF, p2rb_pkg::FMT_ARGB8888,       1'b0, 16'h0000},
		'{16'hF81F, 32'hFF00_FF00, p2rb_pkg::FMT_RGB565_SWAPPED, 1'b1, 16'h00FF},
		'{16'hF81F, 32'hC080_4020, p2rb_pkg::FMT_ARGB8888,       1'b0, 16'h0000},
		'{16'h07E0, 32'h0000_0000, p2rb_pkg::FMT_ARGB8888,       1'b1, 16'h07E0},
		'{16'h07E0, 32'h8012_3456, p2rb_pkg::FMT_ARGB8888,       1'b0, 16'h0000}
	};

	int send_pct_tab [0:2] = '{21, 82, 0};
	int recv_pct_tab [0:2] = '{82, 21, 0};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	p2rb_in_if  in_px ();
	p2rb_out_if out_px ();

	pixel_to_rgb565_blend_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_px       (in_px),
		.out_px      (out_px)
	);

	logic [15:0] expected_px_q [$];
	logic [15:0] bg_model = 16'h0000;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          n_errors = 0;
	int          n_pixels = 0;
	int          n_results = 0;
	int          n_bg_writes = 0;
	int          n_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg, logic [7:0] a);
		int unsigned acc;
		acc = int'(fg) * int'(a) + int'(bg) * (255 - int'(a));
		return 8'(acc / 255);
	endfunction

	function automatic logic [15:0] convert_to_rgb565(logic [31:0] bytes, logic [2:0] fmt,
			logic [15:0] bgc);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		b = bytes[7:0];
		g = bytes[15:8];
		r = bytes[23:16];
		a = bytes[31:24];
		case (fmt)
			p2rb_pkg::FMT_RGB565: return bytes[15:0];
			p2rb_pkg::FMT_RGB565_SWAPPED: return {bytes[7:0], bytes[15:8]};
			p2rb_pkg::FMT_RGB888, p2rb_pkg::FMT_ARGB8888: begin
				if (fmt == p2rb_pkg::FMT_ARGB8888 && a != p2rb_pkg::ALPHA_OPAQUE) begin
					r = mix_channel(r, {bgc[15:11], 3'b000}, a);
					g = mix_channel(g, {bgc[10:5], 2'b00}, a);
					b = mix_channel(b, {bgc[4:0], 3'b000}, a);
				end
				return {r[7:3], g[7:2], b[7:3]};
			end
			default: return bgc;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_pixel(input logic [31:0] bytes, input logic [2:0] fmt,
			input bit typed, input logic [15:0] want);
		while ($urandom_range(99) < send_idle_pct) begin
			in_px.valid <= 1'b0;
			@(negedge clk);
		end
		in_px.valid         <= 1'b1;
		in_px.pixel_bytes   <= bytes;
		in_px.source_format <= fmt;
		@(posedge clk);
		while (!in_px.ready)
			@(posedge clk);
		expected_px_q.push_back(typed ? want : convert_to_rgb565(bytes, fmt, bg_model));
		n_pixels++;
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		in_px.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_px_q.size() != 0);
	endtask

	task automatic write_background(input logic [15:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		bg_model = value;
		n_bg_writes++;
	endtask

	always @(negedge clk) begin
		out_px.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && out_px.valid && out_px.ready) begin
			n_results++;
			if (expected_px_q.size() == 0) begin
				$display("%0t: unexpected item, expected none actual %h", $time,
					out_px.rgb565_pixel);
				n_errors++;
			end else begin
				want = expected_px_q.pop_front();
				if (out_px.rgb565_pixel !== want) begin
					$display("%0t: rgb565_pixel expected %h actual %h", $time, want,
						out_px.rgb565_pixel);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items outstanding", $time, expected_px_q.size());
			$display("pixel_to_rgb565_blend_core: mismatch");
			$finish;
		end
	end

	initial begin
		logic [31:0] bytes;
		logic [2:0]  fmt;
		int          sel;
		in_px.valid         = 1'b0;
		in_px.pixel_bytes   = '0;
		in_px.source_format = p2rb_pkg::FMT_RGB565;
		out_px.ready        = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		arst_n              = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (dir_rows[i].bg != bg_model) begin
				drain_pipeline();
				write_background(dir_rows[i].bg);
			end
			send_pixel(dir_rows[i].bytes, dir_rows[i].fmt, dir_rows[i].typed,
				dir_rows[i].want);
		end

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = send_pct_tab[ph];
			recv_idle_pct = recv_pct_tab[ph];
			for (int blk = 0; blk < BLOCKS_PER_RUN; blk++) begin
				drain_pipeline();
				case ($urandom_range(3))
					0: write_background(16'h0000);
					1: write_background(16'hFFFF);
					default: write_background(16'($urandom()));
				endcase
				for (int k = 0; k < BLOCK_ITEMS; k++) begin
					bytes = $urandom();
					sel   = $urandom_range(99);
					if (sel < 20)
						fmt = p2rb_pkg::FMT_RGB565;
					else if (sel < 35)
						fmt = p2rb_pkg::FMT_RGB565_SWAPPED;
					else if (sel < 55)
						fmt = p2rb_pkg::FMT_RGB888;
					else if (sel < 90)
						fmt = p2rb_pkg::FMT_ARGB8888;
					else
						fmt = 3'($urandom_range(FMT_UNSUP_7, FMT_UNSUP_4));
					// push alpha toward the transparent and opaque ends
					sel = $urandom_range(9);
					if (sel == 0)
						bytes[31:24] = 8'h00;
					else if (sel == 1)
						bytes[31:24] = p2rb_pkg::ALPHA_OPAQUE;
					send_pixel(bytes, fmt, 1'b0, 16'h0000);
				end
			end
		end

		drain_pipeline();
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("converted %0d pixels across all eight format codes, %0d results checked",
			n_pixels, n_results);
		$display("background color rewritten %0d times under three handshake mixes",
			n_bg_writes);
		if (n_errors == 0) begin
			$display("pixel_to_rgb565_blend_core: match");
		end else begin
			$display("pixel_to_rgb565_blend_core: mismatch");
		end
		$finish;
	end

endmodule
